>>> hdl/mant_pkg.sv
`default_nettype none
package mant_pkg;

  localparam int MAX_NOTES = 16;
  localparam int CNT_W     = $clog2(MAX_NOTES + 1);
  localparam int IDX_W     = (MAX_NOTES > 1) ? $clog2(MAX_NOTES) : 1;
  localparam int SLOT_W    = 4;
  localparam int ACNT_W    = 5;

  localparam logic [3:0] MSG_NOTE_ON  = 4'h9;
  localparam logic [3:0] MSG_NOTE_OFF = 4'h8;

  typedef enum logic [2:0] {
    ACT_IGNORED = 3'd0,
    ACT_ADDED   = 3'd1,
    ACT_REMOVED = 3'd2,
    ACT_CLEARED = 3'd3,
    ACT_FULL    = 3'd4
  } act_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WAIT
  } state_t;

  typedef struct packed {
    logic [3:0] chan;
    logic [6:0] key;
    logic [6:0] vel;
  } entry_t;

  typedef struct packed {
    logic ld_event;
    logic ld_next;
    logic ld_head;
  } cell_ctl_t;

  typedef struct packed {
    act_t              action;
    logic [SLOT_W-1:0] slot;
    entry_t            entry;
    logic [ACNT_W-1:0] count;
  } result_t;

endpackage
`default_nettype wire

>>> hdl/mant_in_if.sv
`default_nettype none
interface mant_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] status_byte;
  logic [6:0] key_number;
  logic [6:0] key_velocity;

  modport source (output valid, req_type, status_byte, key_number, key_velocity,
                  input ready);
  modport sink (input valid, req_type, status_byte, key_number, key_velocity,
                output ready);
endinterface
`default_nettype wire

>>> hdl/mant_out_if.sv
`default_nettype none
interface mant_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] action;
  logic [3:0] slot;
  logic [6:0] out_key;
  logic [6:0] out_velocity;
  logic [3:0] out_channel;
  logic [4:0] active_count;

  modport source (output valid, action, slot, out_key, out_velocity, out_channel,
                  active_count, input ready);
  modport sink (input valid, action, slot, out_key, out_velocity, out_channel,
                active_count, output ready);
endinterface
`default_nettype wire

>>> hdl/mant_cell.sv
`default_nettype none
module mant_cell (
  input  wire logic               clk,
  input  wire mant_pkg::cell_ctl_t ctl,
  input  wire mant_pkg::entry_t   event_entry,
  input  wire mant_pkg::entry_t   next_entry,
  input  wire mant_pkg::entry_t   head_entry,
  output mant_pkg::entry_t        entry
);

  mant_pkg::entry_t entry_r;
  mant_pkg::entry_t entry_nxt;

  always_comb begin
    entry_nxt = entry_r;
    priority if (ctl.ld_event) begin
      entry_nxt = event_entry;
    end else if (ctl.ld_next) begin
      entry_nxt = next_entry;
    end else if (ctl.ld_head) begin
      // wrap the head around to the end of the live list
      entry_nxt = head_entry;
    end else begin
      entry_nxt = entry_r;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;

endmodule
`default_nettype wire

>>> hdl/midi_active_note_table.sv
// MIDI active-note table.
// in_ch carries one request per handshake: a MIDI event (note-on appends,
// note-off removes the first entry equal in channel, key and velocity, other
// statuses are ignored) or a clear request that empties the list.
// out_ch returns exactly one result per request: action, slot, the affected
// entry and the number of sounding notes afterwards.
// Notes sit in a row of cells. A note-off rotates the live part of the row
// through the head cell, one position per cycle; a match is dropped on the way
// and the row closes up by itself.
// Clear, note-on and ignored requests go from acceptance through the wait
// state to the output register; a note-off on a non-empty list first scans
// every note held before it. in_ch.ready is high only while no request is in
// work, so a request is not taken before the previous one has left the wait state.
// The finished result sits in an output register; a new request is taken
// while it waits. If out_ch stalls, the following result is held and
// in_ch.ready stays low until the register frees up.
// Reset (rst_n low, synchronous) empties the list and drops any result.
`default_nettype none
module midi_active_note_table (
  input  wire logic  clk,
  input  wire logic  rst_n,
  mant_in_if.sink    in_ch,
  mant_out_if.source out_ch
);

  localparam int N = mant_pkg::MAX_NOTES;

  mant_pkg::state_t  state_r, state_nxt;
  logic [mant_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic [mant_pkg::CNT_W-1:0] tot_r, tot_nxt;
  logic [mant_pkg::IDX_W-1:0] step_r, step_nxt;
  logic [mant_pkg::IDX_W-1:0] slot_r, slot_nxt;
  logic              found_r, found_nxt;
  mant_pkg::entry_t  ev_r, ev_nxt;
  mant_pkg::result_t res_r, res_nxt;
  mant_pkg::result_t out_r, out_nxt;
  logic              out_valid_r, out_valid_nxt;

  mant_pkg::entry_t  in_entry;
  mant_pkg::entry_t  cells [N];
  mant_pkg::cell_ctl_t ctl [N];
  logic              in_acc;
  logic              append;
  logic              shift;
  logic              drop;
  logic              last_step;
  logic              out_free;

  assign in_entry  = '{chan: in_ch.status_byte[3:0], key: in_ch.key_number,
                       vel: in_ch.key_velocity};
  assign in_acc    = in_ch.valid && in_ch.ready;
  assign out_free  = !out_valid_r || out_ch.ready;
  assign last_step = (mant_pkg::CNT_W'(step_r) + mant_pkg::CNT_W'(1)) == tot_r;
  assign drop      = (state_r == mant_pkg::ST_SCAN) && !found_r && (cells[0] == ev_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mant_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (!in_ch.req_type && (in_ch.status_byte[7:4] == mant_pkg::MSG_NOTE_OFF)
              && (cnt_r != '0)) begin
            state_nxt = mant_pkg::ST_SCAN;
          end else begin
            state_nxt = mant_pkg::ST_WAIT;
          end
        end
      end
      mant_pkg::ST_SCAN: begin
        if (last_step) begin
          state_nxt = mant_pkg::ST_WAIT;
        end
      end
      mant_pkg::ST_WAIT: begin
        if (out_free) begin
          state_nxt = mant_pkg::ST_IDLE;
        end
      end
      default: state_nxt = mant_pkg::ST_IDLE;
    endcase
  end

  // datapath control and results
  always_comb begin
    cnt_nxt       = cnt_r;
    tot_nxt       = tot_r;
    step_nxt      = step_r;
    slot_nxt      = slot_r;
    found_nxt     = found_r;
    ev_nxt        = ev_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    append        = 1'b0;
    shift         = 1'b0;
    unique case (state_r)
      mant_pkg::ST_IDLE: begin
        if (in_acc) begin
          ev_nxt   = in_entry;
          tot_nxt  = cnt_r;
          step_nxt = '0;
          found_nxt = 1'b0;
          res_nxt  = '{action: mant_pkg::ACT_IGNORED, slot: '0, entry: '0,
                       count: mant_pkg::ACNT_W'(cnt_r)};
          if (in_ch.req_type) begin
            cnt_nxt = '0;
            res_nxt = '{action: mant_pkg::ACT_CLEARED, slot: '0, entry: '0,
                        count: '0};
          end else if (in_ch.status_byte[7:4] == mant_pkg::MSG_NOTE_ON) begin
            if (cnt_r >= mant_pkg::CNT_W'(N)) begin
              res_nxt = '{action: mant_pkg::ACT_FULL, slot: '0, entry: in_entry,
                          count: mant_pkg::ACNT_W'(cnt_r)};
            end else begin
              append  = 1'b1;
              cnt_nxt = cnt_r + mant_pkg::CNT_W'(1);
              res_nxt = '{action: mant_pkg::ACT_ADDED,
                          slot: mant_pkg::SLOT_W'(cnt_r), entry: in_entry,
                          count: mant_pkg::ACNT_W'(cnt_r + mant_pkg::CNT_W'(1))};
            end
          end
        end
      end
      mant_pkg::ST_SCAN: begin
        shift    = 1'b1;
        step_nxt = step_r + mant_pkg::IDX_W'(1);
        if (drop) begin
          found_nxt = 1'b1;
          slot_nxt  = step_r;
          cnt_nxt   = cnt_r - mant_pkg::CNT_W'(1);
        end
        if (last_step) begin
          if (found_r || drop) begin
            res_nxt = '{action: mant_pkg::ACT_REMOVED,
                        slot: mant_pkg::SLOT_W'(drop ? step_r : slot_r), entry: ev_r,
                        count: mant_pkg::ACNT_W'(cnt_nxt)};
          end else begin
            res_nxt = '{action: mant_pkg::ACT_IGNORED, slot: '0, entry: '0,
                        count: mant_pkg::ACNT_W'(cnt_r)};
          end
        end
      end
      mant_pkg::ST_WAIT: begin
        if (out_free) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // cell row: cell i follows its right neighbor while inside the live list,
  // the last live cell takes the head unless the head is being dropped
  for (genvar i = 0; i < N; i++) begin : g_cell
    assign ctl[i].ld_event = append && (cnt_r == mant_pkg::CNT_W'(i));
    assign ctl[i].ld_next  = shift && (mant_pkg::CNT_W'(i + 1) < cnt_r);
    assign ctl[i].ld_head  = shift && !drop && (mant_pkg::CNT_W'(i + 1) == cnt_r);

    mant_cell u_cell (
      .clk         (clk),
      .ctl         (ctl[i]),
      .event_entry (in_entry),
      .next_entry  (cells[(i + 1 < N) ? i + 1 : i]),
      .head_entry  (cells[0]),
      .entry       (cells[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mant_pkg::ST_IDLE;
      cnt_r       <= '0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tot_r  <= tot_nxt;
    step_r <= step_nxt;
    slot_r <= slot_nxt;
    ev_r   <= ev_nxt;
    res_r  <= res_nxt;
    out_r  <= out_nxt;
  end

  assign in_ch.ready         = (state_r == mant_pkg::ST_IDLE);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.action       = out_r.action;
  assign out_ch.slot         = out_r.slot;
  assign out_ch.out_key      = out_r.entry.key;
  assign out_ch.out_velocity = out_r.entry.vel;
  assign out_ch.out_channel  = out_r.entry.chan;
  assign out_ch.active_count = out_r.count;

endmodule
`default_nettype wire

>>> hdl/mant_checker.sv
`default_nettype none
module mant_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [2:0] action,
  input wire logic [3:0] slot,
  input wire logic [4:0] active_count
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn while stalled");

  // an appended note lands at the old end of the list
  a_add_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (action == mant_pkg::ACT_ADDED) |->
      (active_count == {1'b0, slot} + 5'd1))
    else $error("added slot does not match note count");

  // a clear leaves an empty list
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (action == mant_pkg::ACT_CLEARED) |->
      (active_count == 5'd0) && (slot == 4'd0))
    else $error("clear left notes behind");

  // a full drop only happens with the table full, removal leaves room
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((action == mant_pkg::ACT_FULL) == (active_count == 5'd16))
                  || (action != mant_pkg::ACT_FULL && action != mant_pkg::ACT_REMOVED))
    else $error("note count inconsistent with action");

endmodule

bind midi_active_note_table mant_checker u_mant_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .action       (out_ch.action),
  .slot         (out_ch.slot),
  .active_count (out_ch.active_count)
);
`default_nettype wire
